FILE: rtl/core/cpp_pkg.sv
package cpp_pkg;

  // Default width of the running byte offset.
  localparam int OFFSET_BITS_DEF = 32;

  // Constant pool tags.
  localparam logic [7:0] TAG_UTF8           = 8'd1;
  localparam logic [7:0] TAG_INTEGER        = 8'd3;
  localparam logic [7:0] TAG_FLOAT          = 8'd4;
  localparam logic [7:0] TAG_LONG           = 8'd5;
  localparam logic [7:0] TAG_DOUBLE         = 8'd6;
  localparam logic [7:0] TAG_CLASS          = 8'd7;
  localparam logic [7:0] TAG_STRING         = 8'd8;
  localparam logic [7:0] TAG_FIELDREF       = 8'd9;
  localparam logic [7:0] TAG_METHODREF      = 8'd10;
  localparam logic [7:0] TAG_IFACE_METHOD   = 8'd11;
  localparam logic [7:0] TAG_NAME_AND_TYPE  = 8'd12;
  localparam logic [7:0] TAG_METHOD_HANDLE  = 8'd15;
  localparam logic [7:0] TAG_METHOD_TYPE    = 8'd16;
  localparam logic [7:0] TAG_DYNAMIC        = 8'd17;
  localparam logic [7:0] TAG_INVOKE_DYNAMIC = 8'd18;
  localparam logic [7:0] TAG_MODULE         = 8'd19;
  localparam logic [7:0] TAG_PACKAGE        = 8'd20;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic [15:0] entry_index;
    logic [7:0]  tag;
    logic [63:0] value;
    logic [15:0] ref_first;
    logic [15:0] ref_second;
    logic [15:0] text_length;
    logic [31:0] stream_offset;
    logic [1:0]  status;
    logic        pool_done;
  } cpp_result_t;

  // Payload bytes after the tag; zero for an unknown tag.
  function automatic logic [3:0] payload_len(input logic [7:0] t);
    logic [3:0] len;
    len = 4'd0;
    unique case (t)
      TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE,
      TAG_MODULE, TAG_PACKAGE:                          len = 4'd2;
      TAG_INTEGER, TAG_FLOAT:                           len = 4'd4;
      TAG_LONG, TAG_DOUBLE:                             len = 4'd8;
      TAG_FIELDREF, TAG_METHODREF, TAG_IFACE_METHOD,
      TAG_NAME_AND_TYPE, TAG_DYNAMIC, TAG_INVOKE_DYNAMIC: len = 4'd4;
      TAG_METHOD_HANDLE:                                len = 4'd3;
      default:                                          len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/cpp_if.sv
interface cpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       pool_start;

  modport source (output valid, output data_byte, output pool_start, input ready);
  modport sink   (input valid, input data_byte, input pool_start, output ready);
endinterface

interface cpp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_index;
  logic [7:0]  tag;
  logic [63:0] value;
  logic [15:0] ref_first;
  logic [15:0] ref_second;
  logic [15:0] text_length;
  logic [31:0] stream_offset;
  logic [1:0]  status;
  logic        pool_done;

  modport source (output valid, output entry_index, output tag, output value,
                  output ref_first, output ref_second, output text_length,
                  output stream_offset, output status, output pool_done,
                  input ready);
  modport sink   (input valid, input entry_index, input tag, input value,
                  input ref_first, input ref_second, input text_length,
                  input stream_offset, input status, input pool_done,
                  output ready);
endinterface

FILE: rtl/core/cpp_parse.sv
module cpp_parse #(
  parameter int OFFSET_BITS = cpp_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                pool_start,
  output logic                res_valid,
  output cpp_pkg::cpp_result_t res
);
  import cpp_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_COUNT_LO = 3'd1;
  localparam logic [2:0] PH_TAG      = 3'd2;
  localparam logic [2:0] PH_PAYLOAD  = 3'd3;
  localparam logic [2:0] PH_TEXT     = 3'd4;

  localparam logic [OFFSET_BITS-1:0] OFS_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  logic [2:0]             phase_r, phase_nxt;
  logic [15:0]            total_r, total_nxt;
  logic [15:0]            slot_r, slot_nxt;
  logic [7:0]             tag_r, tag_nxt;
  logic [15:0]            left_r, left_nxt;
  logic [63:0]            shift_r, shift_nxt;
  logic [15:0]            first_r, first_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;

  logic [OFFSET_BITS-1:0] offset_inc;
  logic [63:0]            shift_new;
  logic [15:0]            left_dec;
  logic [3:0]             len;
  logic                   fin;
  logic [1:0]             fin_status;
  logic [1:0]             fin_slots;
  logic [16:0]            slot_sum;

  always_comb begin
    phase_nxt  = phase_r;
    total_nxt  = total_r;
    slot_nxt   = slot_r;
    tag_nxt    = tag_r;
    left_nxt   = left_r;
    shift_nxt  = shift_r;
    first_nxt  = first_r;
    offset_nxt = offset_r;
    res        = '0;
    res_valid  = 1'b0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_slots  = 2'd1;
    offset_inc = offset_r + OFS_ONE;
    shift_new  = {shift_r[55:0], data_byte};
    left_dec   = left_r - 16'd1;
    len        = payload_len(data_byte);
    slot_sum   = '0;

    if (accept && pool_start) begin
      // restart: drop whatever was in flight
      phase_nxt  = PH_COUNT_LO;
      total_nxt  = {data_byte, 8'd0};
      slot_nxt   = '0;
      tag_nxt    = '0;
      left_nxt   = '0;
      shift_nxt  = '0;
      first_nxt  = '0;
      offset_nxt = OFS_ONE;
    end else if (accept && phase_r != PH_IDLE) begin
      offset_nxt = offset_inc;
      unique case (phase_r)
        PH_COUNT_LO: begin
          total_nxt = {total_r[15:8], data_byte};
          if (total_nxt <= 16'd1) begin
            res_valid         = 1'b1;
            res.stream_offset = 32'(offset_inc);
            res.status        = ST_EMPTY;
            res.pool_done     = 1'b1;
            phase_nxt         = PH_IDLE;
          end else begin
            slot_nxt  = 16'd1;
            phase_nxt = PH_TAG;
          end
        end
        PH_TAG: begin
          tag_nxt   = data_byte;
          shift_nxt = '0;
          left_nxt  = {12'd0, len};
          if (len == 4'd0) begin
            fin        = 1'b1;
            fin_status = ST_UNKNOWN;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          shift_nxt = shift_new;
          left_nxt  = left_dec;
          if (left_dec == 16'd0) begin
            priority if (tag_r == TAG_UTF8) begin
              first_nxt = shift_new[15:0];
              if (shift_new[15:0] != 16'd0) begin
                left_nxt  = shift_new[15:0];
                phase_nxt = PH_TEXT;
              end else begin
                fin = 1'b1;
              end
            end else if (tag_r == TAG_INTEGER || tag_r == TAG_FLOAT) begin
              res.value = {32'd0, shift_new[31:0]};
              fin       = 1'b1;
            end else if (tag_r == TAG_LONG || tag_r == TAG_DOUBLE) begin
              res.value = shift_new;
              fin_slots = 2'd2;
              fin       = 1'b1;
            end else if (tag_r == TAG_METHOD_HANDLE) begin
              res.ref_first  = {8'd0, shift_new[23:16]};
              res.ref_second = shift_new[15:0];
              fin            = 1'b1;
            end else if (payload_len(tag_r) == 4'd4) begin
              res.ref_first  = shift_new[31:16];
              res.ref_second = shift_new[15:0];
              fin            = 1'b1;
            end else begin
              res.ref_first = shift_new[15:0];
              fin           = 1'b1;
            end
          end
        end
        PH_TEXT: begin
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            res.text_length = first_r;
            fin             = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase

      if (fin) begin
        slot_sum          = {1'b0, slot_r} + {15'd0, fin_slots};
        res_valid         = 1'b1;
        res.entry_index   = slot_r;
        res.tag           = tag_nxt;
        res.stream_offset = 32'(offset_inc);
        res.status        = fin_status;
        res.pool_done     = slot_sum >= {1'b0, total_r};
        phase_nxt         = res.pool_done ? PH_IDLE : PH_TAG;
        slot_nxt          = slot_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      total_r  <= '0;
      slot_r   <= '0;
      tag_r    <= '0;
      left_r   <= '0;
      first_r  <= '0;
      offset_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      total_r  <= total_nxt;
      slot_r   <= slot_nxt;
      tag_r    <= tag_nxt;
      left_r   <= left_nxt;
      first_r  <= first_nxt;
      offset_r <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  // payload count stays within the longest fixed payload
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> (left_r != 16'd0 && left_r <= 16'd8))
    else $error("payload byte count out of range");

  a_text_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TEXT |-> (left_r != 16'd0 && first_r != 16'd0))
    else $error("text skip with zero count");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.pool_done && !pool_start) |=> phase_r == PH_IDLE)
    else $error("parser not idle after last word of pool");

endmodule

FILE: rtl/core/cpp_obuf.sv
module cpp_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cpp_pkg::cpp_result_t push_data,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cpp_pkg::cpp_result_t out_data
);
  import cpp_pkg::*;

  logic        head_valid_r, head_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  cpp_result_t head_r, head_nxt;
  cpp_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop       = head_valid_r && out_ready;
  assign free      = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (!head_valid_r || pop) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        head_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        head_nxt       = push_data;
        head_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid word without head word");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into full buffer");

endmodule

FILE: rtl/core/class_constant_pool_parser.sv
// Channel  Dir  Handshake              Word
// in_ch    in   valid/ready, sink      data_byte[7:0], pool_start
// out_ch   out  valid/ready, source    entry_index, tag, value[63:0], ref_first,
//                                      ref_second, text_length, stream_offset,
//                                      status, pool_done
//
// One input word per cycle while in_ch.ready is high; a result word is registered
// in the result buffer from the byte that completes its entry (parser state to result register).
// The rate is set by the parser state, which steps once per accepted byte.
// Reset: synchronous, active low; parser goes idle, result buffer empties.
// out_ch stalls are absorbed by a two-word result buffer; in_ch.ready drops
// only while both words are held.
module class_constant_pool_parser #(
  parameter int OFFSET_BITS = cpp_pkg::OFFSET_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  cpp_in_if.sink   in_ch,
  cpp_out_if.source out_ch
);
  import cpp_pkg::*;

  logic        accept;
  logic        res_valid;
  logic        free;
  cpp_result_t res;
  cpp_result_t head;

  // Every byte is taken while the buffer can hold one more result word,
  // whether or not this byte ends an entry.
  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;

  // Byte parser: count, tag, payload shift, text skip, offset tracking.
  cpp_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_ch.data_byte),
    .pool_start (in_ch.pool_start),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register plus skid word.
  cpp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (head)
  );

  assign out_ch.entry_index   = head.entry_index;
  assign out_ch.tag           = head.tag;
  assign out_ch.value         = head.value;
  assign out_ch.ref_first     = head.ref_first;
  assign out_ch.ref_second    = head.ref_second;
  assign out_ch.text_length   = head.text_length;
  assign out_ch.stream_offset = head.stream_offset;
  assign out_ch.status        = head.status;
  assign out_ch.pool_done     = head.pool_done;

endmodule

FILE: test/testbench.sv
module testbench;
  import cpp_pkg::*;

  // Offset width under test; the offset is zero-extended on the result.
  localparam int OFFSET_W    = 16;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int RANDOM_BYTES = 780;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD   = 60;

  // Tag outside the defined set, used for the directed unknown-tag case.
  localparam logic [7:0] TAG_BOGUS = 8'hFF;

  localparam logic [7:0] KNOWN_TAGS [17] = '{
    TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS,
    TAG_STRING, TAG_FIELDREF, TAG_METHODREF, TAG_IFACE_METHOD,
    TAG_NAME_AND_TYPE, TAG_METHOD_HANDLE, TAG_METHOD_TYPE, TAG_DYNAMIC,
    TAG_INVOKE_DYNAMIC, TAG_MODULE, TAG_PACKAGE
  };

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT_LO, PH_TAG, PH_PAYLOAD, PH_TEXT
  } parse_phase_e;

  // One word for the input channel plus driver hints.
  typedef struct {
    logic [7:0] data;
    logic       start;
    bit         settle;  // hold this word until every expected entry is back
    bit         quiet;   // no idling from this word on
  } feed_item_t;

  logic clk;
  logic rst_n;

  cpp_in_if  in_ch();
  cpp_out_if out_ch();

  class_constant_pool_parser #(.OFFSET_BITS(OFFSET_W)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  feed_item_t  byte_feed[$];
  cpp_result_t pending_entries[$];
  logic [7:0]  frame[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  bit settle_next    = 1'b0;
  bit quiet_mode     = 1'b0;
  bit calm           = 1'b0;

  // ---------------------------------------------------------------------------
  // Parser shadow state
  // ---------------------------------------------------------------------------
  parse_phase_e         ph       = PH_IDLE;
  logic [15:0]          total    = '0;
  logic [15:0]          slot     = '0;
  logic [7:0]           cur_tag  = '0;
  logic [15:0]          left     = '0;
  logic [63:0]          shift    = '0;
  logic [15:0]          text_len = '0;
  logic [OFFSET_W-1:0]  offset   = '0;

  function automatic int tag_payload_bytes(input logic [7:0] t);
    case (t)
      TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE, TAG_MODULE,
      TAG_PACKAGE:                                         return 2;
      TAG_INTEGER, TAG_FLOAT:                              return 4;
      TAG_LONG, TAG_DOUBLE:                                return 8;
      TAG_FIELDREF, TAG_METHODREF, TAG_IFACE_METHOD, TAG_NAME_AND_TYPE,
      TAG_DYNAMIC, TAG_INVOKE_DYNAMIC:                     return 4;
      TAG_METHOD_HANDLE:                                   return 3;
      default:                                             return 0;
    endcase
  endfunction

  // Advance the shadow parser by one accepted word; queue the entry it closes.
  task automatic parse_byte(input logic [7:0] b, input logic start);
    cpp_result_t r;
    logic        closes;
    logic [1:0]  st;
    logic [1:0]  slots;
    logic [16:0] next_slot;
    r      = '0;
    closes = 1'b0;
    st     = ST_OK;
    slots  = 2'd1;
    if (start) begin
      // restart from any state; the count high byte is offset 0
      ph       = PH_COUNT_LO;
      total    = {b, 8'h00};
      slot     = '0;
      cur_tag  = '0;
      left     = '0;
      shift    = '0;
      text_len = '0;
      offset   = OFFSET_W'(1);
    end else if (ph != PH_IDLE) begin
      offset = offset + 1'b1;
      case (ph)
        PH_COUNT_LO: begin
          total = total | {8'h00, b};
          if (total <= 16'd1) begin
            // empty pool: slot and tag stay zero
            r.stream_offset = 32'(offset);
            r.status        = ST_EMPTY;
            r.pool_done     = 1'b1;
            ph              = PH_IDLE;
            pending_entries.push_back(r);
          end else begin
            slot = 16'd1;
            ph   = PH_TAG;
          end
        end
        PH_TAG: begin
          cur_tag = b;
          shift   = '0;
          left    = 16'(tag_payload_bytes(b));
          if (left == 16'd0) begin
            closes = 1'b1;
            st     = ST_UNKNOWN;
          end else begin
            ph = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          shift = {shift[55:0], b};
          left  = left - 16'd1;
          if (left == 16'd0) begin
            closes = 1'b1;
            case (cur_tag)
              TAG_UTF8: begin
                text_len = shift[15:0];
                if (text_len != 16'd0) begin
                  left   = text_len;
                  ph     = PH_TEXT;
                  closes = 1'b0;
                end
              end
              TAG_INTEGER, TAG_FLOAT: r.value = {32'h0, shift[31:0]};
              TAG_LONG, TAG_DOUBLE: begin
                r.value = shift;
                slots   = 2'd2;
              end
              TAG_METHOD_HANDLE: begin
                r.ref_first  = {8'h00, shift[23:16]};
                r.ref_second = shift[15:0];
              end
              default: begin
                if (tag_payload_bytes(cur_tag) == 4) begin
                  r.ref_first  = shift[31:16];
                  r.ref_second = shift[15:0];
                end else begin
                  r.ref_first = shift[15:0];
                end
              end
            endcase
          end
        end
        PH_TEXT: begin
          left = left - 16'd1;
          if (left == 16'd0) begin
            r.text_length = text_len;
            closes        = 1'b1;
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (closes) begin
      next_slot       = {1'b0, slot} + 17'(slots);
      r.entry_index   = slot;
      r.tag           = cur_tag;
      r.stream_offset = 32'(offset);
      r.status        = st;
      // a wide entry running past the last slot still ends the pool
      r.pool_done     = (next_slot >= {1'b0, total});
      if (r.pool_done) ph = PH_IDLE;
      else             ph = PH_TAG;
      slot            = next_slot[15:0];
      pending_entries.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic s);
    feed_item_t it;
    it.data     = b;
    it.start    = s;
    it.settle   = settle_next;
    it.quiet    = quiet_mode;
    settle_next = 1'b0;
    byte_feed.push_back(it);
  endtask

  // Payload bytes lean toward the all-zero and all-one extremes now and then.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_tag();
    logic [7:0] t;
    if ($urandom_range(0, 19) < 17) return KNOWN_TAGS[$urandom_range(0, 16)];
    t = 8'($urandom);
    while (tag_payload_bytes(t) != 0) t = 8'($urandom);
    return t;
  endfunction

  // Append one well-formed entry to frame; report the slots it takes.
  task automatic build_entry(input logic [7:0] tg, output int slots);
    logic [15:0] len;
    frame.push_back(tg);
    slots = (tg == TAG_LONG || tg == TAG_DOUBLE) ? 2 : 1;
    if (tg == TAG_UTF8) begin
      len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(7, 40))
                                        : 16'($urandom_range(0, 6));
      frame.push_back(len[15:8]);
      frame.push_back(len[7:0]);
      repeat (len) frame.push_back(8'($urandom));
    end else begin
      repeat (tag_payload_bytes(tg)) frame.push_back(rand_byte());
    end
  endtask

  // A pool of `count` slots; cut >= 0 truncates it after that many entry
  // bytes, and the next pool start then drops whatever is in progress.
  task automatic add_pool(input logic [15:0] count, input int cut, output int n);
    int s;
    int w;
    frame.delete();
    frame.push_back(count[15:8]);
    frame.push_back(count[7:0]);
    s = 1;
    while (s < int'(count) && (cut < 0 || frame.size() < cut + 2)) begin
      build_entry(pick_tag(), w);
      s += w;
    end
    n = frame.size();
    if (cut >= 0 && n > cut + 2) n = cut + 2;
    for (int i = 0; i < n; i++) push_byte(frame[i], i == 0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: sample at rise, drive at fall
  // ---------------------------------------------------------------------------
  bit         byte_taken;
  int         tx_gap    = 0;
  int         tx_steady = 0;
  feed_item_t tx_word;

  always begin : byte_driver
    @(posedge clk);
    byte_taken = rst_n && in_ch.valid && in_ch.ready;
    if (byte_taken) parse_byte(in_ch.data_byte, in_ch.pool_start);
    @(negedge clk);
    if (tx_steady > 0) tx_steady--;
    else if ($urandom_range(0, 39) == 0) tx_steady = $urandom_range(20, 60);
    if (!rst_n) begin
      in_ch.valid = 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid = 1'b0;
      end else if (byte_feed.size() == 0 ||
                   (byte_feed[0].settle && pending_entries.size() != 0)) begin
        in_ch.valid = 1'b0;
      end else if (!byte_feed[0].quiet && tx_steady == 0 &&
                   $urandom_range(0, 4) == 0) begin
        // idle burst: this one included, extended by tx_gap more
        tx_gap      = $urandom_range(0, 2);
        in_ch.valid = 1'b0;
      end else begin
        tx_word          = byte_feed.pop_front();
        in_ch.valid      = 1'b1;
        in_ch.data_byte  = tx_word.data;
        in_ch.pool_start = tx_word.start;
        if (tx_word.quiet) calm = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each entry word against the oldest expectation
  // ---------------------------------------------------------------------------
  cpp_result_t rx_word;
  int          rx_gap    = 0;
  int          rx_hold   = 0;
  int          rx_steady = 0;

  always begin : result_monitor
    @(posedge clk);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_word.entry_index   = out_ch.entry_index;
      rx_word.tag           = out_ch.tag;
      rx_word.value         = out_ch.value;
      rx_word.ref_first     = out_ch.ref_first;
      rx_word.ref_second    = out_ch.ref_second;
      rx_word.text_length   = out_ch.text_length;
      rx_word.stream_offset = out_ch.stream_offset;
      rx_word.status        = out_ch.status;
      rx_word.pool_done     = out_ch.pool_done;
      results_seen++;
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected entry word, expected none, got slot %0h tag %0h",
                 $time, rx_word.entry_index, rx_word.tag);
        mismatch_count++;
      end else begin
        cpp_result_t want;
        want = pending_entries.pop_front();
        check_field("entry_index",   64'(want.entry_index),   64'(rx_word.entry_index));
        check_field("tag",           64'(want.tag),           64'(rx_word.tag));
        check_field("value",         want.value,              rx_word.value);
        check_field("ref_first",     64'(want.ref_first),     64'(rx_word.ref_first));
        check_field("ref_second",    64'(want.ref_second),    64'(rx_word.ref_second));
        check_field("text_length",   64'(want.text_length),   64'(rx_word.text_length));
        check_field("stream_offset", 64'(want.stream_offset), 64'(rx_word.stream_offset));
        check_field("status",        64'(want.status),        64'(rx_word.status));
        check_field("pool_done",     64'(want.pool_done),     64'(rx_word.pool_done));
      end
      // long back-pressure: the result buffer fills and input ready drops
      if (results_seen == 25 || results_seen == 120) rx_hold = LONG_HOLD;
    end
    @(negedge clk);
    if (rx_steady > 0) rx_steady--;
    else if ($urandom_range(0, 39) == 0) rx_steady = $urandom_range(20, 60);
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready = 1'b0;
    end else if (!calm && rx_steady == 0 && $urandom_range(0, 4) == 0) begin
      rx_gap       = $urandom_range(0, 2);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int fed;
    int n;
    int pick;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.pool_start = 1'b0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;

    // Directed words.
    push_byte(8'hA5, 1'b0);                      // stray byte while idle: ignored
    push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b0);  // empty pool, count 0
    push_byte(8'h00, 1'b1); push_byte(8'h01, 1'b0);  // empty pool, count 1
    // count 3: empty text in slot 1, then a long in the last slot
    push_byte(8'h00, 1'b1); push_byte(8'h03, 1'b0);
    push_byte(TAG_UTF8, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(TAG_LONG, 1'b0);
    repeat (8) push_byte(8'hFF, 1'b0);
    // max count: dynamic constant, method handle, then an integer cut short
    push_byte(8'hFF, 1'b1); push_byte(8'hFF, 1'b0);
    push_byte(TAG_DYNAMIC, 1'b0);
    push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(TAG_METHOD_HANDLE, 1'b0);
    push_byte(8'h09, 1'b0); push_byte(8'hAB, 1'b0); push_byte(8'hCD, 1'b0);
    push_byte(TAG_INTEGER, 1'b0); push_byte(8'h80, 1'b0);
    // restart mid-entry into a pool holding one unknown tag
    push_byte(8'h00, 1'b1); push_byte(8'h02, 1'b0);
    push_byte(TAG_BOGUS, 1'b0);

    // Random part; the sender first waits for the directed entries.
    settle_next = 1'b1;
    fed = 0;
    while (fed < RANDOM_BYTES) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        add_pool(($urandom_range(0, 7) == 0) ? 16'($urandom_range(2, 40))
                                             : 16'($urandom_range(2, 12)), -1, n);
        fed += n;
      end else if (pick < 17) begin
        add_pool(16'($urandom), $urandom_range(0, 14), n);
        fed += n;
      end else if (pick < 19) begin
        add_pool(16'($urandom_range(0, 1)), -1, n);
        fed += n;
      end else begin
        // noise; ignored when the parser is idle, junk entries otherwise
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      end
      if ($urandom_range(0, 49) == 0) settle_next = 1'b1;
    end

    // Quiet tail: back-to-back words, no idling on either side.
    settle_next = 1'b1;
    quiet_mode  = 1'b1;
    repeat (6) add_pool(16'($urandom_range(2, 8)), -1, n);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (byte_feed.size() != 0 || in_ch.valid || pending_entries.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_entries.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
